>>> rtl/core/bvr_pkg.sv
// ----------------------------------------------------------------------------
// bvr_pkg
// shared types and constants of the base velocity ramp
// ----------------------------------------------------------------------------
package bvr_pkg;

    localparam int VEL_W  = 16;
    localparam int LIM_W  = 15;
    localparam int TICK_W = 8;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // action codes
    localparam logic [1:0] ACT_JOY  = 2'd0;
    localparam logic [1:0] ACT_ODOM = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MAX_VEL_LIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIN_VEL_LIN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX_VEL_ANG   = 3'd2;
    localparam logic [IDX_W-1:0] REG_ACC_STEP_LIN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_ACC_STEP_ANG  = 3'd4;
    localparam logic [IDX_W-1:0] REG_WINDUP_LIN    = 3'd5;
    localparam logic [IDX_W-1:0] REG_WINDUP_ANG    = 3'd6;
    localparam logic [IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd7;

    localparam logic [TICK_W-1:0] IDLE_MAX = 8'hFF;

    typedef struct packed {
        logic        [LIM_W-1:0]  max_vel_lin;
        logic signed [VEL_W-1:0]  min_vel_lin;
        logic        [LIM_W-1:0]  max_vel_ang;
        logic        [LIM_W-1:0]  acc_step_lin;
        logic        [LIM_W-1:0]  acc_step_ang;
        logic        [LIM_W-1:0]  windup_lin;
        logic        [LIM_W-1:0]  windup_ang;
        logic        [TICK_W-1:0] timeout_ticks;
    } cfg_t;

endpackage

>>> rtl/core/bvr_cfg_regs.sv
// ----------------------------------------------------------------------------
// bvr_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module bvr_cfg_regs
    import bvr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_vel_lin   <= 15'd4096;
            cfg_reg.min_vel_lin   <= -16'sd2048;
            cfg_reg.max_vel_ang   <= 15'd12288;
            cfg_reg.acc_step_lin  <= 15'd137;
            cfg_reg.acc_step_ang  <= 15'd410;
            cfg_reg.windup_lin    <= 15'd1024;
            cfg_reg.windup_ang    <= 15'd3072;
            cfg_reg.timeout_ticks <= 8'd7;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_VEL_LIN:   cfg_reg.max_vel_lin   <= cfg_data[LIM_W-1:0];
                REG_MIN_VEL_LIN:   cfg_reg.min_vel_lin   <= $signed(cfg_data);
                REG_MAX_VEL_ANG:   cfg_reg.max_vel_ang   <= cfg_data[LIM_W-1:0];
                REG_ACC_STEP_LIN:  cfg_reg.acc_step_lin  <= cfg_data[LIM_W-1:0];
                REG_ACC_STEP_ANG:  cfg_reg.acc_step_ang  <= cfg_data[LIM_W-1:0];
                REG_WINDUP_LIN:    cfg_reg.windup_lin    <= cfg_data[LIM_W-1:0];
                REG_WINDUP_ANG:    cfg_reg.windup_ang    <= cfg_data[LIM_W-1:0];
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/bvr_scale.sv
// ----------------------------------------------------------------------------
// bvr_scale
// stick axis times speed limit, rounded half up and saturated to 16 bits
// ----------------------------------------------------------------------------
module bvr_scale
    import bvr_pkg::*;
(
    input  logic signed [VEL_W-1:0] axis,
    input  logic signed [VEL_W:0]   scale,
    output logic signed [VEL_W-1:0] target
);

    logic signed [2*VEL_W:0]   prod;
    logic signed [2*VEL_W+1:0] biased;
    logic signed [19:0]        quot;

    assign prod   = axis * scale;
    assign biased = {prod[2*VEL_W], prod} + 34'sd8192;
    // arithmetic shift gives floor, matching both rounding branches
    assign quot   = biased[2*VEL_W+1:14];

    always_comb
    begin
        if (quot > 20'sd32767)
            target = 16'sh7FFF;
        else if (quot < -20'sd32768)
            target = 16'sh8000;
        else
            target = quot[VEL_W-1:0];
    end

endmodule

>>> rtl/core/bvr_ramp.sv
// ----------------------------------------------------------------------------
// bvr_ramp
// windup clamp around measured speed, then one acceleration step to target
// ----------------------------------------------------------------------------
module bvr_ramp
    import bvr_pkg::*;
(
    input  logic signed [VEL_W-1:0] present,
    input  logic signed [VEL_W-1:0] meas,
    input  logic signed [VEL_W-1:0] desired,
    input  logic        [LIM_W-1:0] windup,
    input  logic        [LIM_W-1:0] step,
    output logic signed [VEL_W-1:0] result
);

    logic signed [VEL_W+1:0] pres_x;
    logic signed [VEL_W+1:0] meas_x;
    logic signed [VEL_W+1:0] des_x;
    logic signed [VEL_W+1:0] wind_x;
    logic signed [VEL_W+1:0] step_x;
    logic signed [VEL_W+1:0] lim_hi;
    logic signed [VEL_W+1:0] lim_lo;
    logic signed [VEL_W+1:0] clamped;
    logic signed [VEL_W+1:0] up;
    logic signed [VEL_W+1:0] dn;
    logic signed [VEL_W+1:0] ramped;

    assign pres_x = {{2{present[VEL_W-1]}}, present};
    assign meas_x = {{2{meas[VEL_W-1]}}, meas};
    assign des_x  = {{2{desired[VEL_W-1]}}, desired};
    assign wind_x = $signed({3'b000, windup});
    assign step_x = $signed({3'b000, step});

    assign lim_hi = meas_x + wind_x;
    assign lim_lo = meas_x - wind_x;

    always_comb
    begin
        if (!present[VEL_W-1])
            clamped = (pres_x < lim_hi) ? pres_x : lim_hi;
        else
            clamped = (pres_x > lim_lo) ? pres_x : lim_lo;

        up = clamped + step_x;
        dn = clamped - step_x;

        if (des_x > clamped)
            ramped = (des_x < up) ? des_x : up;
        else
            ramped = (des_x > dn) ? des_x : dn;
    end

    // the result always lies between clamped and desired, both 16 bit
    assign result = ramped[VEL_W-1:0];

endmodule

>>> rtl/core/base_velocity_ramp_unit.sv
// ----------------------------------------------------------------------------
// base_velocity_ramp_unit
// two-axis acceleration limited velocity command shaper for a mobile base
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while in_stall is low. An accepted item
// lands in the input register; from there a single pass of logic (target
// scaling with two 16x17 multipliers, or windup clamp and ramp per axis)
// updates the state and, for a stop or a ramped tick, loads the result
// register. Items that give no result proceed even while a result waits on
// a stalled output.
// ----------------------------------------------------------------------------
module base_velocity_ramp_unit
    import bvr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              action,
    input  logic                    deadman,
    input  logic signed [VEL_W-1:0] axis_lin,
    input  logic signed [VEL_W-1:0] axis_ang,
    input  logic signed [VEL_W-1:0] odom_lin,
    input  logic signed [VEL_W-1:0] odom_ang,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [VEL_W-1:0] cmd_lin,
    output logic signed [VEL_W-1:0] cmd_ang,
    output logic                    is_stop
);

    cfg_t cfg;

    bvr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    logic                    in_valid_reg;
    logic [1:0]              action_reg;
    logic                    deadman_reg;
    logic signed [VEL_W-1:0] axis_lin_reg;
    logic signed [VEL_W-1:0] axis_ang_reg;
    logic signed [VEL_W-1:0] odom_lin_reg;
    logic signed [VEL_W-1:0] odom_ang_reg;

    // state
    logic                    active_reg, active_next;
    logic signed [VEL_W-1:0] target_lin_reg, target_lin_next;
    logic signed [VEL_W-1:0] target_ang_reg, target_ang_next;
    logic signed [VEL_W-1:0] out_lin_reg, out_lin_next;
    logic signed [VEL_W-1:0] out_ang_reg, out_ang_next;
    logic signed [VEL_W-1:0] meas_lin_reg, meas_lin_next;
    logic signed [VEL_W-1:0] meas_ang_reg, meas_ang_next;
    logic [TICK_W-1:0]       idle_reg, idle_next;

    // result register
    logic                    out_valid_reg;
    logic signed [VEL_W-1:0] cmd_lin_reg;
    logic signed [VEL_W-1:0] cmd_ang_reg;
    logic                    is_stop_reg;

    logic                    res_valid;
    logic                    res_stop;
    logic                    fire;
    logic                    out_free;
    logic                    in_take;

    logic signed [VEL_W:0]   scale_lin;
    logic signed [VEL_W:0]   scale_ang;
    logic signed [VEL_W-1:0] tgt_lin;
    logic signed [VEL_W-1:0] tgt_ang;
    logic signed [VEL_W-1:0] ramp_lin;
    logic signed [VEL_W-1:0] ramp_ang;
    logic [TICK_W-1:0]       idle_inc;

    // forward or reverse linear scale
    always_comb
    begin
        if (axis_lin_reg > 16'sd0)
            scale_lin = $signed({2'b00, cfg.max_vel_lin});
        else
            scale_lin = -$signed({cfg.min_vel_lin[VEL_W-1], cfg.min_vel_lin});
    end

    assign scale_ang = $signed({2'b00, cfg.max_vel_ang});

    bvr_scale u_scale_lin
    (
        .axis   (axis_lin_reg),
        .scale  (scale_lin),
        .target (tgt_lin)
    );

    bvr_scale u_scale_ang
    (
        .axis   (axis_ang_reg),
        .scale  (scale_ang),
        .target (tgt_ang)
    );

    bvr_ramp u_ramp_lin
    (
        .present (out_lin_reg),
        .meas    (meas_lin_reg),
        .desired (target_lin_reg),
        .windup  (cfg.windup_lin),
        .step    (cfg.acc_step_lin),
        .result  (ramp_lin)
    );

    bvr_ramp u_ramp_ang
    (
        .present (out_ang_reg),
        .meas    (meas_ang_reg),
        .desired (target_ang_reg),
        .windup  (cfg.windup_ang),
        .step    (cfg.acc_step_ang),
        .result  (ramp_ang)
    );

    assign idle_inc = (idle_reg == IDLE_MAX) ? IDLE_MAX : idle_reg + 8'd1;

    always_comb
    begin
        active_next     = active_reg;
        target_lin_next = target_lin_reg;
        target_ang_next = target_ang_reg;
        out_lin_next    = out_lin_reg;
        out_ang_next    = out_ang_reg;
        meas_lin_next   = meas_lin_reg;
        meas_ang_next   = meas_ang_reg;
        idle_next       = idle_reg;
        res_valid       = 1'b0;
        res_stop        = 1'b0;

        case (action_reg)
            ACT_JOY:
            begin
                idle_next = '0;
                if (!deadman_reg)
                begin
                    res_valid = 1'b1;
                    res_stop  = 1'b1;
                end
                else
                begin
                    active_next     = 1'b1;
                    target_lin_next = tgt_lin;
                    target_ang_next = tgt_ang;
                end
            end
            ACT_ODOM:
            begin
                meas_lin_next = odom_lin_reg;
                meas_ang_next = odom_ang_reg;
            end
            ACT_TICK:
            begin
                idle_next = idle_inc;
                if (idle_inc > cfg.timeout_ticks)
                begin
                    res_valid = 1'b1;
                    res_stop  = 1'b1;
                end
                else if (active_reg)
                begin
                    out_lin_next = ramp_lin;
                    out_ang_next = ramp_ang;
                    res_valid    = 1'b1;
                end
            end
            default: ;
        endcase

        if (res_stop)
        begin
            active_next     = 1'b0;
            target_lin_next = '0;
            target_ang_next = '0;
            out_lin_next    = '0;
            out_ang_next    = '0;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && (out_free || !res_valid);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg   <= action;
            deadman_reg  <= deadman;
            axis_lin_reg <= axis_lin;
            axis_ang_reg <= axis_ang;
            odom_lin_reg <= odom_lin;
            odom_ang_reg <= odom_ang;
        end
    end

    // block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            target_lin_reg <= '0;
            target_ang_reg <= '0;
            out_lin_reg    <= '0;
            out_ang_reg    <= '0;
            meas_lin_reg   <= '0;
            meas_ang_reg   <= '0;
            idle_reg       <= IDLE_MAX;
        end
        else if (fire)
        begin
            active_reg     <= active_next;
            target_lin_reg <= target_lin_next;
            target_ang_reg <= target_ang_next;
            out_lin_reg    <= out_lin_next;
            out_ang_reg    <= out_ang_next;
            meas_lin_reg   <= meas_lin_next;
            meas_ang_reg   <= meas_ang_next;
            idle_reg       <= idle_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            cmd_lin_reg <= out_lin_next;
            cmd_ang_reg <= out_ang_next;
            is_stop_reg <= res_stop;
        end
    end

    assign out_valid = out_valid_reg;
    assign cmd_lin   = cmd_lin_reg;
    assign cmd_ang   = cmd_ang_reg;
    assign is_stop   = is_stop_reg;

endmodule
